// ----- design/pru_pkg.sv -----
// Shared types and constants for the capture-record UDP payload extractor.
// No dependencies; imported by every module of the block.
package pru_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 65536;

    localparam int TIME_W     = 42;
    localparam int LEN_W      = 17;
    localparam int STRIP_W    = 7;
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 4;

    // Byte positions inside the captured frame
    localparam int ETYPE_HI_POS  = 12;
    localparam int ETYPE_LO_POS  = 13;
    localparam int ETH_HDR_BYTES = 6 + 6 + 2;
    localparam int UDP_HDR_BYTES = 8;
    localparam int PROTO_POS     = 23;
    localparam int IHL_MIN       = 5;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Record header: index of its last byte
    localparam logic [3:0] HDR_LAST_POS = 4'd15;

    // floor(us / 1000) == ((us >> 3) * USEC_DIV_MULT) >> USEC_DIV_SHIFT for 32-bit us
    localparam logic [29:0] USEC_DIV_MULT  = 30'd549755814;
    localparam int          USEC_DIV_SHIFT = 36;
    localparam logic [9:0]  MS_PER_SEC     = 10'd1000;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SKIPPED   = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NOT_UDP   = 3'd3,
        ST_SHORT     = 3'd4,
        ST_CAP_END   = 3'd5
    } t_status;

    typedef struct packed {
        logic              byte_valid;
        logic [7:0]        payload_byte;
        logic              last_of_record;
        t_status           record_status;
        logic [TIME_W-1:0] time_ms;
        logic [LEN_W-1:0]  payload_length;
    } t_result;

    typedef struct packed {
        logic failed;
        logic in_header;
    } t_pru_status;

endpackage

// ----- design/pru_time_conv.sv -----
// Record timestamp to milliseconds: seconds*1000 + microseconds/1000.
// Two register stages; uses pru_pkg constants.
module pru_time_conv
    import pru_pkg::*;
(
    input  logic              i_clk,
    input  logic [31:0]       i_sec,
    input  logic [31:0]       i_usec,
    output logic [TIME_W-1:0] o_time_ms
);

    logic [TIME_W-1:0] r_sec_ms;
    logic [58:0]       r_usec_prod;
    logic [TIME_W-1:0] r_time_ms;
    logic [TIME_W-1:0] n_sec_ms;
    logic [58:0]       n_usec_prod;

    assign n_sec_ms    = {10'b0, i_sec} * {32'b0, MS_PER_SEC};
    // divide by 1000 as a divide by 8 followed by a reciprocal multiply for 125
    assign n_usec_prod = {30'b0, i_usec[31:3]} * {29'b0, USEC_DIV_MULT};

    always_ff @(posedge i_clk) begin
        r_sec_ms    <= n_sec_ms;
        r_usec_prod <= n_usec_prod;
        r_time_ms   <= r_sec_ms + {19'b0, r_usec_prod[58:USEC_DIV_SHIFT]};
    end

    assign o_time_ms = r_time_ms;

endmodule

// ----- design/pru_parser.sv -----
// Record parser: header capture, Ethernet/IPv4/UDP checks, payload selection
// and the result register. Uses pru_pkg types; time comes from pru_time_conv.
module pru_parser
    import pru_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_link_eth,
    input  logic              i_in_valid,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_end,
    input  logic              i_out_ready,
    input  logic [TIME_W-1:0] i_time_ms,
    output logic              o_fire,
    output logic [31:0]       o_sec,
    output logic [31:0]       o_usec,
    output logic              o_out_valid,
    output t_result           o_result,
    output t_pru_status       o_status
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

    logic               r_hdr, n_hdr;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [31:0]        r_sec, n_sec;
    logic [31:0]        r_usec, n_usec;
    logic [31:0]        r_caplen, n_caplen;
    logic [7:0]         r_eth_hi, n_eth_hi;
    logic [STRIP_W-1:0] r_strip, n_strip;
    logic               r_skip, n_skip;
    logic [POS_W-1:0]   r_emit, n_emit;
    logic               r_failed, n_failed;
    logic               r_out_v;
    t_result            r_out;

    logic               fire;
    logic               res_v;
    t_result            res;
    logic [3:0]         hp;
    logic [POS_W-1:0]   p1;
    logic [POS_W-1:0]   emit1;
    logic               last;
    logic [STRIP_W-1:0] strip_new;
    logic [STRIP_W-1:0] strip_eff;
    logic               at_ihl;
    logic               skip_now;
    logic               do_emit;

    assign fire = i_in_valid && (!r_out_v || i_out_ready);

    assign hp        = r_pos[3:0];
    assign p1        = r_pos + 1'b1;
    assign emit1     = r_emit + 1'b1;
    assign last      = (32'(p1) == r_caplen);
    assign at_ihl    = (r_pos == POS_W'(ETH_HDR_BYTES));
    assign strip_new = STRIP_W'(ETH_HDR_BYTES + UDP_HDR_BYTES)
                     + STRIP_W'({i_in_byte[3:0], 2'b00});
    assign strip_eff = at_ihl ? strip_new : r_strip;
    assign skip_now  = r_skip || ((r_pos == POS_W'(ETYPE_LO_POS))
                     && ({r_eth_hi, i_in_byte} != ETHERTYPE_IPV4));

    always_comb begin
        n_hdr    = r_hdr;
        n_pos    = r_pos;
        n_sec    = r_sec;
        n_usec   = r_usec;
        n_caplen = r_caplen;
        n_eth_hi = r_eth_hi;
        n_strip  = r_strip;
        n_skip   = r_skip;
        n_emit   = r_emit;
        n_failed = r_failed;
        res_v    = 1'b0;
        res      = '0;
        do_emit  = 1'b0;

        if (!r_failed) begin
            if (r_hdr) begin
                if (i_in_end) begin
                    res_v              = 1'b1;
                    res.last_of_record = 1'b1;
                    if (r_pos == '0) begin
                        res.record_status = ST_CAP_END;
                    end else begin
                        res.record_status = ST_SHORT;
                        n_failed          = 1'b1;
                    end
                end else begin
                    case (hp[3:2])
                        2'd0:    n_sec[8*hp[1:0] +: 8]    = i_in_byte;
                        2'd1:    n_usec[8*hp[1:0] +: 8]   = i_in_byte;
                        2'd2:    n_caplen[8*hp[1:0] +: 8] = i_in_byte;
                        default: ;
                    endcase
                    if (hp != HDR_LAST_POS) begin
                        n_pos = p1;
                    end else begin
                        n_hdr    = 1'b0;
                        n_pos    = '0;
                        n_emit   = '0;
                        n_strip  = '0;
                        n_skip   = 1'b0;
                        n_eth_hi = '0;
                        if (r_caplen > 32'(MAX_PACKET_BYTES)) begin
                            res_v              = 1'b1;
                            res.last_of_record = 1'b1;
                            res.record_status  = ST_TOO_LARGE;
                            res.time_ms        = i_time_ms;
                            n_failed           = 1'b1;
                        end else if (r_caplen == '0) begin
                            res_v              = 1'b1;
                            res.last_of_record = 1'b1;
                            res.time_ms        = i_time_ms;
                            if (i_link_eth) begin
                                res.record_status = ST_SHORT;
                                n_failed          = 1'b1;
                            end else begin
                                res.record_status = ST_OK;
                                n_hdr             = 1'b1;
                            end
                        end
                    end
                end
            end else if (i_in_end) begin
                res_v              = 1'b1;
                res.last_of_record = 1'b1;
                res.record_status  = ST_SHORT;
                res.time_ms        = i_time_ms;
                res.payload_length = LEN_W'(r_emit);
                n_failed           = 1'b1;
            end else begin
                n_pos = p1;
                if (!i_link_eth) begin
                    do_emit = 1'b1;
                end else begin
                    if (r_pos == POS_W'(ETYPE_HI_POS)) begin
                        n_eth_hi = i_in_byte;
                    end
                    n_skip = skip_now;
                    if (skip_now) begin
                        // drop the record body, report once at its last byte
                        if (last) begin
                            res_v              = 1'b1;
                            res.last_of_record = 1'b1;
                            res.record_status  = ST_SKIPPED;
                            res.time_ms        = i_time_ms;
                            n_hdr              = 1'b1;
                            n_pos              = '0;
                        end
                    end else if (at_ihl && (i_in_byte[3:0] < 4'(IHL_MIN))) begin
                        res_v              = 1'b1;
                        res.last_of_record = 1'b1;
                        res.record_status  = ST_SHORT;
                        res.time_ms        = i_time_ms;
                        n_failed           = 1'b1;
                    end else begin
                        n_strip = strip_eff;
                        if ((r_pos == POS_W'(PROTO_POS)) && (i_in_byte != PROTO_UDP)) begin
                            res_v              = 1'b1;
                            res.last_of_record = 1'b1;
                            res.record_status  = ST_NOT_UDP;
                            res.time_ms        = i_time_ms;
                            n_failed           = 1'b1;
                        end else if ((strip_eff != '0)
                                     && (32'(r_pos) >= 32'(strip_eff))) begin
                            do_emit = 1'b1;
                        end else if (last) begin
                            res_v              = 1'b1;
                            res.last_of_record = 1'b1;
                            res.time_ms        = i_time_ms;
                            if ((strip_eff != '0) && (32'(p1) == 32'(strip_eff))) begin
                                res.record_status = ST_OK;
                                n_hdr             = 1'b1;
                                n_pos             = '0;
                            end else begin
                                res.record_status = ST_SHORT;
                                n_failed          = 1'b1;
                            end
                        end
                    end
                end
                if (do_emit) begin
                    n_emit           = emit1;
                    res_v            = 1'b1;
                    res.byte_valid   = 1'b1;
                    res.payload_byte = i_in_byte;
                    if (last) begin
                        res.last_of_record = 1'b1;
                        res.record_status  = ST_OK;
                        res.time_ms        = i_time_ms;
                        res.payload_length = LEN_W'(emit1);
                        n_hdr              = 1'b1;
                        n_pos              = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr    <= 1'b1;
            r_pos    <= '0;
            r_strip  <= '0;
            r_skip   <= 1'b0;
            r_emit   <= '0;
            r_failed <= 1'b0;
            r_eth_hi <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (fire) begin
                r_hdr    <= n_hdr;
                r_pos    <= n_pos;
                r_strip  <= n_strip;
                r_skip   <= n_skip;
                r_emit   <= n_emit;
                r_failed <= n_failed;
                r_eth_hi <= n_eth_hi;
                r_out_v  <= res_v;
            end else if (i_out_ready) begin
                r_out_v  <= 1'b0;
            end
        end
    end

    // stamps, length and result payload carry no reset
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_sec    <= n_sec;
            r_usec   <= n_usec;
            r_caplen <= n_caplen;
            if (res_v) begin
                r_out <= res;
            end
        end
    end

    assign o_fire      = fire;
    assign o_sec       = r_sec;
    assign o_usec      = r_usec;
    assign o_out_valid = r_out_v;
    assign o_result    = r_out;
    assign o_status    = '{failed: r_failed, in_header: r_hdr};

endmodule

// ----- design/pcap_record_udp_payload_extractor.sv -----
// Top level of the capture-record UDP payload extractor.
// Depends on pru_pkg, pru_parser and pru_time_conv.
// Usage:
//   Slave stream: one byte of the capture-record stream (the part after the
//   global header) per transfer on i_s_tdata; i_s_tuser[0] set means no byte,
//   the capture has ended. Master stream: one result per transfer; payload
//   bytes with tuser[0] set, and a final result per record (tlast) carrying
//   status, time in milliseconds and payload length.
//   Config stream: i_cfg_data selects Ethernet decapsulation (1, reset value)
//   or raw pass-through (0). Write it only while the block is idle.
// Timing:
//   An input transfer lands in an input register and is parsed from there; its
//   result, if any, goes to the master-side result register. One byte per cycle
//   is sustained while i_m_tready is high; the single parse stage sets it.
//   The millisecond stamp comes from a two-stage unit fed by the header fields.
// Reset and stall:
//   Synchronous active-low reset returns to the start of a record header and
//   clears the failed state. When i_m_tready is low the result register holds
//   and one more input byte is buffered, then o_s_tready drops. After a fatal
//   status the block consumes input and gives no result until reset.
module pcap_record_udp_payload_extractor
    import pru_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [7:0] stream_byte
    input  logic [S_TUSER_W-1:0] i_s_tuser,   // [0] capture_end
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [7:0] payload_byte, [49:8] time_ms,
                                              // [66:50] payload_length, [71:67] zero
    output logic                 o_m_tlast,   // last_of_record
    output logic [M_TUSER_W-1:0] o_m_tuser,   // [0] byte_valid, [3:1] record_status
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data   // link_is_ethernet
);

    logic              r_link_eth;
    logic              r_in_v;
    logic [7:0]        r_in_byte;
    logic              r_in_end;
    logic              fire;
    logic              s_accept;
    logic [31:0]       sec;
    logic [31:0]       usec;
    logic [TIME_W-1:0] time_ms;
    logic              out_valid;
    t_result           result;
    t_pru_status       status;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_in_v || fire;
    assign s_accept    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_eth <= 1'b1;
            r_in_v     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_link_eth <= i_cfg_data;
            end
            if (s_accept) begin
                r_in_v <= 1'b1;
            end else if (fire) begin
                r_in_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_tdata[7:0];
            r_in_end  <= i_s_tuser[0];
        end
    end

    pru_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_link_eth (r_link_eth),
        .i_in_valid (r_in_v),
        .i_in_byte  (r_in_byte),
        .i_in_end   (r_in_end),
        .i_out_ready(i_m_tready),
        .i_time_ms  (time_ms),
        .o_fire     (fire),
        .o_sec      (sec),
        .o_usec     (usec),
        .o_out_valid(out_valid),
        .o_result   (result),
        .o_status   (status)
    );

    pru_time_conv u_time_conv (
        .i_clk    (i_clk),
        .i_sec    (sec),
        .i_usec   (usec),
        .o_time_ms(time_ms)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tlast  = result.last_of_record;
    assign o_m_tuser  = {result.record_status, result.byte_valid};
    assign o_m_tdata  = {5'b0, result.payload_length, result.time_ms, result.payload_byte};

    // A result without a payload byte always closes a record or the stream
    a_nobyte_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tlast)
        else $error("result without byte is not last");

    // Mid-record results carry no status, time or length
    a_mid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |->
            (o_m_tuser[3:1] == ST_OK) && (o_m_tdata[66:8] == '0))
        else $error("non-last result carries record fields");

    // Entering the failed state always comes with a final fatal result
    a_fail_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(status.failed) |-> o_m_tvalid && o_m_tlast && !o_m_tuser[0]
            && ((o_m_tuser[3:1] == ST_TOO_LARGE) || (o_m_tuser[3:1] == ST_NOT_UDP)
                || (o_m_tuser[3:1] == ST_SHORT)))
        else $error("failure without fatal result");

    // Once failed and drained, nothing more comes out
    a_fail_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.failed && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result after failure");

endmodule
